// ===== hdl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// shared types, codes and defaults for the periodic timer scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    // default sizing
    localparam int SLOTS_DEF     = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int TIME_BITS_DEF = 48;

    // fixed field widths
    localparam int PERIOD_W = 28;
    localparam int SLOT_ID_W = 4;
    localparam int TIME_US_W = 48;

    // input function codes
    localparam logic [1:0] FN_TICK  = 2'd0;
    localparam logic [1:0] FN_REG   = 2'd1;
    localparam logic [1:0] FN_UNREG = 2'd2;

    // result codes
    localparam logic [1:0] EV_FIRED = 2'd0;
    localparam logic [1:0] EV_GRANT = 2'd1;
    localparam logic [1:0] EV_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [PERIOD_W-1:0] period;
        logic [3:0]          slot;
    } t_in_word;

    typedef struct packed {
        logic [1:0]           event_res;
        logic [SLOT_ID_W-1:0] slot_id;
        logic [TIME_US_W-1:0] time_us;
        logic                 last;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic accept;       // latch the input word
        logic tick_start;   // set target, clear fired marks, restart scan
        logic unreg;        // free the slot named by the input word
        logic reg_commit;   // grant a slot or report full
        logic scan;         // issue one table read
        logic scan_init;    // restart the scan for the next firing
        logic fire_now;     // pull the clock up to the chosen due time
        logic fire_adv;     // due time plus period
        logic fire_commit;  // write back due time, present the firing
        logic tick_end;     // clock to old clock plus one
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic scan_last;
        logic found;
        logic multi;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pts_ctrl
// sequencer for register, unregister and tick words
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [1:0]      i_func,
    output logic                 o_in_ready,
    output pts_pkg::t_cmd        o_cmd,
    input  wire pts_pkg::t_status i_sts
);
    import pts_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_REG       = 3'd1;
    localparam logic [2:0] ST_SCAN      = 3'd2;
    localparam logic [2:0] ST_SCAN_WAIT = 3'd3;
    localparam logic [2:0] ST_FIRE_NOW  = 3'd4;
    localparam logic [2:0] ST_FIRE_ADV  = 3'd5;
    localparam logic [2:0] ST_FIRE_WR   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_func)
                        FN_TICK: begin
                            o_cmd.tick_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                        FN_REG: begin
                            n_state = ST_REG;
                        end
                        FN_UNREG: begin
                            o_cmd.unreg = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REG: begin
                if (i_sts.out_free) begin
                    o_cmd.reg_commit = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT: begin
                n_state = ST_FIRE_NOW;
            end
            ST_FIRE_NOW: begin
                if (i_sts.found) begin
                    o_cmd.fire_now = 1'b1;
                    n_state        = ST_FIRE_ADV;
                end else begin
                    o_cmd.tick_end = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_FIRE_ADV: begin
                o_cmd.fire_adv = 1'b1;
                n_state        = ST_FIRE_WR;
            end
            ST_FIRE_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.fire_commit = 1'b1;
                    if (i_sts.multi) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN;
                    end else begin
                        o_cmd.tick_end = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/pts_dpath.sv =====
// ----------------------------------------------------------------------------
// pts_dpath
// clock, slot table memories, earliest-due scan and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pts_dpath #(
    parameter int SLOTS     = pts_pkg::SLOTS_DEF,
    parameter int FRAC_BITS = pts_pkg::FRAC_BITS_DEF,
    parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pts_pkg::t_cmd     i_cmd,
    output pts_pkg::t_status       o_sts,
    input  wire pts_pkg::t_in_word i_in_data,
    output pts_pkg::t_out_word     o_out_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready
);
    import pts_pkg::*;

    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TF_BITS  = TIME_BITS + FRAC_BITS;
    localparam int DUE_BITS = (TF_BITS > 64) ? 64 : TF_BITS;

    // clock and tick target
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_target;
    logic [DUE_BITS-1:0]  r_tfx;

    // per-slot flags
    logic [SLOTS-1:0] r_active;
    logic [SLOTS-1:0] r_fired;

    // slot table
    logic [DUE_BITS-1:0] mem_due [SLOTS];
    logic [PERIOD_W-1:0] mem_per [SLOTS];

    // latched period, already clamped to at least one microsecond
    logic [PERIOD_W-1:0] r_per_in;

    // scan read pipeline
    logic [SLOT_W-1:0]   r_addr;
    logic                r_rd_vld;
    logic [SLOT_W-1:0]   r_rd_idx;
    logic [DUE_BITS-1:0] r_rd_due;
    logic [PERIOD_W-1:0] r_rd_per;

    // best candidate so far
    logic                r_found;
    logic                r_multi;
    logic [SLOT_W-1:0]   r_best_idx;
    logic [DUE_BITS-1:0] r_best_due;
    logic [PERIOD_W-1:0] r_best_per;
    logic [DUE_BITS-1:0] r_best_d;
    logic [DUE_BITS-1:0] r_adv;

    // result register
    t_out_word r_out;
    logic      r_out_vld;

    logic [PERIOD_W-1:0] per_one;
    logic [PERIOD_W-1:0] per_clamped;
    logic [TF_BITS-1:0]  now_wide;
    logic [DUE_BITS-1:0] clk_fx;
    logic [TF_BITS-1:0]  tgt_wide;
    logic [TIME_BITS-1:0] tgt_next;
    logic [DUE_BITS-1:0] rd_d;
    logic                rd_elig;
    logic                rd_better;
    logic [SLOT_W-1:0]   free_idx;
    logic                any_free;
    logic [DUE_BITS-1:0] best_due_sh;
    logic [DUE_BITS-1:0] due_fin;
    logic                out_free;
    logic                we_due;
    logic                we_per;
    logic [SLOT_W-1:0]   w_addr;
    logic [DUE_BITS-1:0] w_due;
    logic                unreg_ok;

    // a lies strictly after b in serial order
    function automatic logic later_than(input logic [DUE_BITS-1:0] a,
                                        input logic [DUE_BITS-1:0] b);
        logic [DUE_BITS-1:0] g;
        g = a - b;
        return (g != '0) && !g[DUE_BITS-1];
    endfunction

    assign per_one     = PERIOD_W'(1) << FRAC_BITS;
    assign per_clamped = (i_in_data.period < per_one) ? per_one : i_in_data.period;

    assign now_wide = TF_BITS'(r_now) << FRAC_BITS;
    assign clk_fx   = now_wide[DUE_BITS-1:0];
    assign tgt_next = r_now + TIME_BITS'(1);
    assign tgt_wide = TF_BITS'(tgt_next) << FRAC_BITS;

    // scan compare on the registered read
    assign rd_d      = r_tfx - r_rd_due;
    assign rd_elig   = r_rd_vld && r_active[r_rd_idx] && !r_fired[r_rd_idx]
                       && !rd_d[DUE_BITS-1];
    assign rd_better = !r_found || (rd_d > r_best_d);

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end
    assign any_free = ~&r_active;

    assign best_due_sh = r_best_due >> FRAC_BITS;
    assign due_fin     = later_than(clk_fx, r_adv) ? (clk_fx + DUE_BITS'(r_best_per)) : r_adv;

    assign out_free = !r_out_vld || i_out_ready;
    assign unreg_ok = (32'(i_in_data.slot) < SLOTS);

    // table write port
    always_comb begin
        we_due = 1'b0;
        we_per = 1'b0;
        w_addr = r_best_idx;
        w_due  = due_fin;
        if (i_cmd.reg_commit && any_free) begin
            we_due = 1'b1;
            we_per = 1'b1;
            w_addr = free_idx;
            w_due  = clk_fx + DUE_BITS'(r_per_in);
        end else if (i_cmd.fire_commit) begin
            we_due = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_due) begin
            mem_due[w_addr] <= w_due;
        end
        if (we_per) begin
            mem_per[w_addr] <= r_per_in;
        end
        if (i_cmd.scan) begin
            r_rd_due <= mem_due[r_addr];
            r_rd_per <= mem_per[r_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_active  <= '0;
            r_fired   <= '0;
            r_rd_vld  <= 1'b0;
            r_addr    <= '0;
            r_found   <= 1'b0;
            r_multi   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.tick_start || i_cmd.scan_init) begin
                r_addr  <= '0;
                r_found <= 1'b0;
                r_multi <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_addr <= r_addr + SLOT_W'(1);
                end
                if (rd_elig) begin
                    r_found <= 1'b1;
                    r_multi <= r_multi || r_found;
                end
            end
            if (i_cmd.tick_start) begin
                r_fired <= '0;
            end else if (i_cmd.fire_commit) begin
                r_fired[r_best_idx] <= 1'b1;
            end
            if (i_cmd.unreg && unreg_ok) begin
                r_active[SLOT_W'(i_in_data.slot)] <= 1'b0;
            end else if (i_cmd.reg_commit && any_free) begin
                r_active[free_idx] <= 1'b1;
            end
            if (i_cmd.tick_end) begin
                r_now <= r_target;
            end else if (i_cmd.fire_now && later_than(r_best_due, clk_fx)) begin
                r_now <= TIME_BITS'(best_due_sh);
            end
            if (i_cmd.reg_commit || i_cmd.fire_commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_per_in <= per_clamped;
        end
        if (i_cmd.tick_start) begin
            r_target <= tgt_next;
            r_tfx    <= tgt_wide[DUE_BITS-1:0];
        end
        if (i_cmd.scan) begin
            r_rd_idx <= r_addr;
        end
        if (rd_elig && rd_better && !i_cmd.scan_init) begin
            r_best_idx <= r_rd_idx;
            r_best_due <= r_rd_due;
            r_best_per <= r_rd_per;
            r_best_d   <= rd_d;
        end
        if (i_cmd.fire_adv) begin
            r_adv <= r_best_due + DUE_BITS'(r_best_per);
        end
        if (i_cmd.reg_commit) begin
            r_out.event_res <= any_free ? EV_GRANT : EV_FULL;
            r_out.slot_id   <= any_free ? SLOT_ID_W'(free_idx) : '0;
            r_out.time_us   <= '0;
            r_out.last      <= 1'b1;
        end else if (i_cmd.fire_commit) begin
            r_out.event_res <= EV_FIRED;
            r_out.slot_id   <= SLOT_ID_W'(r_best_idx);
            r_out.time_us   <= TIME_US_W'(r_now);
            r_out.last      <= !r_multi;
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_vld;

    assign o_sts.out_free  = out_free;
    assign o_sts.scan_last = (r_addr == SLOT_W'(SLOTS - 1));
    assign o_sts.found     = r_found;
    assign o_sts.multi     = r_multi;

endmodule

`default_nettype wire

// ===== hdl/periodic_timer_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_top
// A table of SLOTS periodic timers on a wrapping microsecond clock. A register
// word takes the lowest free slot and answers with a grant (or full); an
// unregister word frees a slot with no answer; a tick word moves the clock
// on by one microsecond and answers with one fired word per due slot,
// earliest due first, the final one marked last. A register word may wait on
// the result register. Each firing of a tick needs a full pass over the slot
// table, whose single read port gives one slot per cycle, followed by the
// clock pull-up, due-time advance and write-back steps, which may wait on
// the result register. Input words are taken only while the sequencer is
// idle, but a finished result may still be waiting on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_scheduler_top #(
    parameter int SLOTS     = pts_pkg::SLOTS_DEF,
    parameter int FRAC_BITS = pts_pkg::FRAC_BITS_DEF,
    parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input word channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pts_pkg::t_in_word i_in_data,
    // result word channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pts_pkg::t_out_word     o_out_data
);
    import pts_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status sts;

    // sequencer: idle, register, scan passes and the firing steps
    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // datapath: clock, slot table, scan compare, result register
    pts_dpath #(
        .SLOTS     (SLOTS),
        .FRAC_BITS (FRAC_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire

// ===== hdl/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker
// port-level checks on both word channels, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pts_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire pts_pkg::t_in_word  i_in_data,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire pts_pkg::t_out_word o_out_data
);
    import pts_pkg::*;

    // a waiting input word stays
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input word dropped or changed while waiting");

    // a stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word dropped or changed while stalled");

    // only defined result codes
    a_res_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.event_res == EV_FIRED ||
                         o_out_data.event_res == EV_GRANT ||
                         o_out_data.event_res == EV_FULL))
        else $error("undefined result code");

    // register answers are single words with no time
    a_reg_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res != EV_FIRED
        |-> o_out_data.last && o_out_data.time_us == '0)
        else $error("register answer not last or carries a time");

    // a full answer names no slot
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == EV_FULL |-> o_out_data.slot_id == '0)
        else $error("full answer names a slot");

endmodule

bind periodic_timer_scheduler_top pts_checker u_pts_checker (.*);

`default_nettype wire

// ===== verif/pts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_scoreboard
// Watches both word channels of the periodic timer scheduler. It keeps its own
// copy of the slot table and the microsecond clock, works out the result words
// of every accepted input word and compares the result words in order.
// ----------------------------------------------------------------------------
module pts_scoreboard (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  pts_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  pts_pkg::t_out_word i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import pts_pkg::*;

    localparam int SLOTS     = SLOTS_DEF;
    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int TIME_BITS = TIME_BITS_DEF;
    localparam int DUE_W     = (TIME_BITS + FRAC_BITS > 64) ? 64 : TIME_BITS + FRAC_BITS;

    typedef logic [DUE_W-1:0]     t_due;
    typedef logic [TIME_BITS-1:0] t_usec;

    t_usec               clock_us;
    t_due                due_fx    [SLOTS];
    logic [PERIOD_W-1:0] period_fx [SLOTS];
    logic                slot_busy [SLOTS];
    t_out_word           result_q  [$];

    function automatic t_due clock_fx();
        return t_due'(clock_us) << FRAC_BITS;
    endfunction

    // serial order on the due-time ring
    function automatic logic due_after(t_due a, t_due b);
        t_due gap;
        gap = a - b;
        return (gap != '0) && !gap[DUE_W-1];
    endfunction

    task automatic run_register(logic [PERIOD_W-1:0] per_in);
        logic [PERIOD_W-1:0] per;
        t_out_word           w;
        per = per_in;
        if (per < (1 << FRAC_BITS))
            per = PERIOD_W'(1) << FRAC_BITS;
        w = '0;
        w.event_res = EV_FULL;
        w.last = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i]) begin
                period_fx[i] = per;
                due_fx[i] = clock_fx() + t_due'(per);
                slot_busy[i] = 1'b1;
                w.event_res = EV_GRANT;
                w.slot_id = i[SLOT_ID_W-1:0];
                break;
            end
        end
        result_q.push_back(w);
    endtask

    task automatic run_tick();
        t_usec     next_us;
        t_due      next_fx;
        t_due      lead;
        t_due      best_lead;
        logic      done_mark [SLOTS];
        int        best;
        int        n_fired;
        t_out_word w;
        next_us = clock_us + t_usec'(1);
        next_fx = t_due'(next_us) << FRAC_BITS;
        n_fired = 0;
        foreach (done_mark[i])
            done_mark[i] = 1'b0;
        for (int n = 0; n < SLOTS; n++) begin
            best = -1;
            best_lead = '0;
            // earliest due first, lower slot wins a tie
            for (int i = 0; i < SLOTS; i++) begin
                lead = next_fx - due_fx[i];
                if (slot_busy[i] && !done_mark[i] && !lead[DUE_W-1]
                        && (best < 0 || lead > best_lead)) begin
                    best = i;
                    best_lead = lead;
                end
            end
            if (best < 0)
                break;
            if (due_after(due_fx[best], clock_fx()))
                clock_us = t_usec'(due_fx[best] >> FRAC_BITS);
            due_fx[best] = due_fx[best] + t_due'(period_fx[best]);
            // behind schedule: restart from the clock
            if (due_after(clock_fx(), due_fx[best]))
                due_fx[best] = clock_fx() + t_due'(period_fx[best]);
            done_mark[best] = 1'b1;
            w = '0;
            w.event_res = EV_FIRED;
            w.slot_id = best[SLOT_ID_W-1:0];
            w.time_us = clock_us;
            result_q.push_back(w);
            n_fired++;
        end
        clock_us = next_us;
        if (n_fired > 0)
            result_q[result_q.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            clock_us = '0;
            foreach (slot_busy[i]) begin
                due_fx[i] = '0;
                period_fx[i] = '0;
                slot_busy[i] = 1'b0;
            end
            result_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result word res %0d slot %0d time %0d last %0d",
                             $time, i_out_data.event_res, i_out_data.slot_id,
                             i_out_data.time_us, i_out_data.last);
                end else begin
                    want = result_q.pop_front();
                    if (i_out_data !== want) begin
                        o_fail_count++;
                        if (i_out_data.event_res !== want.event_res)
                            $display("%0t: event_res expected %0d got %0d",
                                     $time, want.event_res, i_out_data.event_res);
                        if (i_out_data.slot_id !== want.slot_id)
                            $display("%0t: slot_id expected %0d got %0d",
                                     $time, want.slot_id, i_out_data.slot_id);
                        if (i_out_data.time_us !== want.time_us)
                            $display("%0t: time_us expected %0d got %0d",
                                     $time, want.time_us, i_out_data.time_us);
                        if (i_out_data.last !== want.last)
                            $display("%0t: last expected %0d got %0d",
                                     $time, want.last, i_out_data.last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.func)
                    FN_TICK: begin
                        run_tick();
                    end
                    FN_REG: begin
                        run_register(i_in_data.period);
                    end
                    FN_UNREG: begin
                        if (i_in_data.slot < SLOTS)
                            slot_busy[i_in_data.slot] = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = result_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the periodic timer scheduler with a directed opening (short and
// extreme periods, bad unregisters, the unused function code, a full table,
// a tick firing many due slots) and then random words in four idling phases. A
// long receiver hold-off backs the block up. The checker beside the block
// predicts and compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import pts_pkg::*;

    // function code the block must ignore
    localparam logic [1:0] FN_NONE = 2'd3;

    localparam int ONE_US       = 1 << FRAC_BITS_DEF;
    localparam int RANDOM_WORDS = 480;
    localparam int HOLD_CYCLES  = 300;
    // a tick that fires nothing is the longest silent word
    localparam int TAIL_CYCLES  = 60;
    localparam int LIMIT_NS     = 30_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_data;

    int   fail_count;
    int   pending;
    // idle chances in percent, changed per phase
    int   send_gap_pct   = 0;
    int   recv_stall_pct = 0;
    // asks the receiver for one long hold-off
    logic hold_req = 1'b0;

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    periodic_timer_scheduler_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    pts_scoreboard u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_word make_word(logic [1:0] f, logic [PERIOD_W-1:0] p,
                                           logic [3:0] s);
        t_in_word w;
        w.func = f;
        w.period = p;
        w.slot = s;
        return w;
    endfunction

    // mostly ticks and short periods so that slots keep firing; some sub-microsecond
    // and full-width periods, and now and then the ignored code
    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 52)
            w.func = FN_TICK;
        else if (pick < 74)
            w.func = FN_REG;
        else if (pick < 96)
            w.func = FN_UNREG;
        else
            w.func = FN_NONE;
        pick = $urandom_range(9);
        if (pick < 7)
            w.period = PERIOD_W'($urandom_range(12 * ONE_US, ONE_US));
        else if (pick == 7)
            w.period = PERIOD_W'($urandom_range(ONE_US - 1));
        else
            w.period = PERIOD_W'($urandom());
        w.slot = 4'($urandom_range(15));
        return w;
    endfunction

    // entered and left at a falling edge; valid stays up between back-to-back
    // words, ready is sampled at the rising edge
    task automatic send_word(input t_in_word w);
        if ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin : receiver
        int   hold_left;
        logic hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // stimulus
    initial begin
        // reset held low at the start, released at a falling edge
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // short periods are raised to one microsecond, the widest is kept
        send_word(make_word(FN_REG, 28'd0, 4'd0));
        send_word(make_word(FN_REG, 28'(ONE_US - 1), 4'd0));
        send_word(make_word(FN_REG, 28'(ONE_US), 4'd0));
        send_word(make_word(FN_REG, 28'hFFF_FFFF, 4'd0));
        // one and a half microseconds, fractional due times
        send_word(make_word(FN_REG, 28'(ONE_US + ONE_US / 2), 4'd0));
        repeat (3) send_word(make_word(FN_TICK, '0, 4'd0));
        // free an active slot, then the same one again and an unused one
        send_word(make_word(FN_UNREG, '0, 4'd1));
        send_word(make_word(FN_UNREG, '0, 4'd1));
        send_word(make_word(FN_UNREG, '1, 4'd15));
        send_word(make_word(FN_NONE, '1, 4'd15));
        send_word(make_word(FN_TICK, '1, 4'd15));
        // fill the table: slot 1 first, then 5 to 15
        for (int k = 0; k < 12; k++)
            send_word(make_word(FN_REG, 28'(ONE_US * (k % 3 + 1)), 4'd0));
        // no free slot left
        send_word(make_word(FN_REG, 28'(ONE_US), 4'd0));
        // every slot but the long one is due within a few ticks
        repeat (2) send_word(make_word(FN_TICK, '0, 4'd0));

        // drain, then start the random part under a long receiver hold-off
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_gap_pct = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 79;
                end
                default: begin
                    send_gap_pct = 38;
                    recv_stall_pct = 38;
                end
            endcase
            repeat (RANDOM_WORDS / 4) send_word(random_word());
        end

        // let the last results out, then a short quiet stretch
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== periodic_timer_scheduler_top.f =====
hdl/pts_pkg.sv
hdl/pts_ctrl.sv
hdl/pts_dpath.sv
hdl/periodic_timer_scheduler_top.sv
hdl/pts_checker.sv
verif/pts_checker.sv
verif/testbench.sv
